// ===== src/horizon_packet_frame_parser_top_defines.svh =====
// Assertion macros for the horizon packet frame parser.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef HORIZON_PACKET_FRAME_PARSER_TOP_DEFINES_SVH
`define HORIZON_PACKET_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define HFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hfp check failed: same-cycle implication");

// next-cycle implication
`define HFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hfp check failed: next-cycle implication");

`endif

// ===== src/hfp_pkg.sv =====
// Shared types, codes and the frame unpack function for the packet frame parser.
// No dependencies.
package hfp_pkg;

  localparam int HFP_QDEPTH = 4;
  localparam int HFP_QPTR_W = $clog2(HFP_QDEPTH);
  localparam int HFP_QCNT_W = $clog2(HFP_QDEPTH + 1);

  localparam logic [1:0] KIND_MATRIX  = 2'd0;
  localparam logic [1:0] KIND_SEGMENT = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [2:0] ST_VALID      = 3'd0;
  localparam logic [2:0] ST_VERSION    = 3'd1;
  localparam logic [2:0] ST_SHORT      = 3'd2;
  localparam logic [2:0] ST_MATRIX_TRC = 3'd3;
  localparam logic [2:0] ST_NO_SEG_CNT = 3'd4;
  localparam logic [2:0] ST_SIZE       = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } hfp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  msg_count;
    logic [5:0]  head_bits;
    logic [5:0]  part0_class;
    logic [11:0] part0_value;
    logic [5:0]  part1_class;
    logic [11:0] part1_value;
    logic [5:0]  part2_class;
    logic [11:0] part2_value;
    logic [2:0]  status;
    logic        last;
  } hfp_out_t;

  // front -> back command: an optional frame, then an optional status
  typedef struct packed {
    logic        has_frame;
    logic        seg;
    logic [63:0] frame;      // byte 0 in [63:56]
    logic        has_status;
    logic [2:0]  status;
  } hfp_cmd_t;

  function automatic hfp_out_t hfp_decode_frame(input logic [63:0] f, input logic seg);
    hfp_out_t   o;
    logic [7:0] hi;
    logic [7:0] lo;
    o           = '0;
    o.kind      = seg ? KIND_SEGMENT : KIND_MATRIX;
    o.msg_count = {f[63:56], f[55:54]};
    o.head_bits = f[53:48];
    for (int i = 0; i < 3; i++) begin
      hi = f[47 - 16*i -: 8];
      lo = f[39 - 16*i -: 8];
      if (seg) begin
        if (i == 0) begin o.part0_class = lo[5:0]; o.part0_value = {2'b00, hi, lo[7:6]}; end
        if (i == 1) begin o.part1_class = lo[5:0]; o.part1_value = {2'b00, hi, lo[7:6]}; end
        if (i == 2) begin o.part2_class = lo[5:0]; o.part2_value = {2'b00, hi, lo[7:6]}; end
      end else begin
        if (i == 0) begin o.part0_class = {2'b00, hi[7:4]}; o.part0_value = {hi[3:0], lo}; end
        if (i == 1) begin o.part1_class = {2'b00, hi[7:4]}; o.part1_value = {hi[3:0], lo}; end
        if (i == 2) begin o.part2_class = {2'b00, hi[7:4]}; o.part2_value = {hi[3:0], lo}; end
      end
    end
    return o;
  endfunction

endpackage

// ===== src/horizon_packet_frame_parser_top.sv =====
// Top level of the horizon packet frame parser: config register, front, queue, back.
// Depends on hfp_pkg, hfp_front, hfp_queue, hfp_back and the defines header.
//
//   channel | ports                          | accepted when
//   --------+--------------------------------+----------------------------
//   input   | in_push, in_item, in_full      | in_push && !in_full
//   result  | out_empty, out_item, out_pop   | out_pop && !out_empty
//   config  | cfg_valid, cfg_data, cfg_ready | cfg_valid && cfg_ready
//
// One byte is taken per cycle while in_full is low; results reach out_item via the
// command queue and the back end's output register. The back end emits one item
// per cycle while out_pop keeps up; a frame byte ending a packet yields two items.
// Reset (rst_n low, synchronous) clears the parse state, queue and output
// valid; expected_version returns to 0. in_full rises only when the 4-entry
// command queue is full; out_pop stalls never block input until then.
`include "horizon_packet_frame_parser_top_defines.svh"

module horizon_packet_frame_parser_top
  import hfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input items
  input  logic       in_push,
  input  hfp_in_t    in_item,
  output logic       in_full,
  // result items
  output logic       out_empty,
  input  logic       out_pop,
  output hfp_out_t   out_item,
  // config write
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  output logic       cfg_ready
);

  logic [7:0] exp_version_r;
  logic       acc;
  logic       q_push;
  hfp_cmd_t   q_wcmd;
  logic       q_full;
  logic       q_pop;
  hfp_cmd_t   q_head;
  logic       q_empty;

  // single config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      exp_version_r <= cfg_data;
    end
  end

  // a byte is taken whenever the queue has room for what it may produce
  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  hfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_item     (in_item),
    .exp_version (exp_version_r),
    .q_push      (q_push),
    .q_cmd       (q_wcmd)
  );

  hfp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  hfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // no command is ever offered to a full queue
  `HFP_ASSERT_NOW(a_no_overflow, q_push, !q_full)
  // only status items carry last
  `HFP_ASSERT_NOW(a_last_on_status, !out_empty, out_item.last == (out_item.kind == KIND_STATUS))
  // kind is never the unused code
  `HFP_ASSERT_NOW(a_kind_legal, !out_empty, out_item.kind <= KIND_STATUS)
  // an empty queue and an idle output mean nothing is shown next cycle
  `HFP_ASSERT_NEXT(a_drain, out_empty && q_empty, out_empty)

endmodule

// ===== src/hfp_front.sv =====
// Front end: byte-level packet parser that builds frame/status commands.
// Depends on hfp_pkg.
module hfp_front
  import hfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  hfp_in_t  in_item,
  input  logic [7:0] exp_version,
  output logic     q_push,
  output hfp_cmd_t q_cmd
);

  typedef enum logic [7:0] {
    PH_VERSION = 8'b0000_0001,
    PH_MCNT_HI = 8'b0000_0010,
    PH_MCNT_LO = 8'b0000_0100,
    PH_MATRIX  = 8'b0000_1000,
    PH_SCNT_HI = 8'b0001_0000,
    PH_SCNT_LO = 8'b0010_0000,
    PH_SEGMENT = 8'b0100_0000,
    PH_AFTER   = 8'b1000_0000
  } hfp_phase_t;

  localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

  hfp_phase_t  phase_r, phase_nxt;
  logic [19:0] total_r, total_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] mcnt_r, mcnt_nxt;
  logic [15:0] scnt_r, scnt_nxt;
  logic [15:0] left_r, left_nxt;
  logic        ver_ok_r, ver_ok_nxt;
  logic [7:0]  fb_r [7];
  logic        fb_we;
  logic        emit;
  logic [19:0] exp_size;
  logic [2:0]  status;
  logic [7:0]  b;

  assign b = in_item.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    mcnt_nxt   = mcnt_r;
    scnt_nxt   = scnt_r;
    left_nxt   = left_r;
    ver_ok_nxt = ver_ok_r;
    fb_we      = 1'b0;
    emit       = 1'b0;
    if (acc) begin
      if (total_r != TOTAL_MAX) total_nxt = total_r + 20'd1;
      case (phase_r)
        PH_VERSION: begin
          ver_ok_nxt = (b == exp_version);
          phase_nxt  = PH_MCNT_HI;
        end
        PH_MCNT_HI: begin
          mcnt_nxt  = {8'h00, b};
          phase_nxt = PH_MCNT_LO;
        end
        PH_MCNT_LO: begin
          mcnt_nxt  = {mcnt_r[7:0], b};
          left_nxt  = {mcnt_r[7:0], b};
          idx_nxt   = '0;
          phase_nxt = ({mcnt_r[7:0], b} != 16'd0) ? PH_MATRIX : PH_SCNT_HI;
        end
        PH_MATRIX, PH_SEGMENT: begin
          if (idx_r != 3'd7) begin
            fb_we   = 1'b1;
            idx_nxt = idx_r + 3'd1;
          end else begin
            emit     = 1'b1;
            idx_nxt  = '0;
            left_nxt = left_r - 16'd1;
            if (left_r == 16'd1)
              phase_nxt = (phase_r == PH_SEGMENT) ? PH_AFTER : PH_SCNT_HI;
          end
        end
        PH_SCNT_HI: begin
          scnt_nxt  = {8'h00, b};
          phase_nxt = PH_SCNT_LO;
        end
        PH_SCNT_LO: begin
          scnt_nxt  = {scnt_r[7:0], b};
          left_nxt  = {scnt_r[7:0], b};
          idx_nxt   = '0;
          phase_nxt = ({scnt_r[7:0], b} != 16'd0) ? PH_SEGMENT : PH_AFTER;
        end
        default: ;
      endcase
    end

    // status reflects the state after this byte
    exp_size = 20'd5 + {1'b0, mcnt_nxt, 3'b000} + {1'b0, scnt_nxt, 3'b000};
    if (!ver_ok_nxt)                                    status = ST_VERSION;
    else if (total_nxt < 20'd4)                         status = ST_SHORT;
    else if (phase_nxt inside {PH_MCNT_HI, PH_MCNT_LO, PH_MATRIX}) status = ST_MATRIX_TRC;
    else if (phase_nxt inside {PH_SCNT_HI, PH_SCNT_LO}) status = ST_NO_SEG_CNT;
    else if (phase_nxt != PH_AFTER)                     status = ST_SIZE;
    else if (total_nxt == exp_size)                     status = ST_VALID;
    else                                                status = ST_SIZE;

    if (acc && in_item.end_of_packet) begin
      phase_nxt  = PH_VERSION;
      total_nxt  = '0;
      idx_nxt    = '0;
      mcnt_nxt   = '0;
      scnt_nxt   = '0;
      left_nxt   = '0;
      ver_ok_nxt = 1'b0;
    end
  end

  assign q_push           = acc && (emit || in_item.end_of_packet);
  assign q_cmd.has_frame  = emit;
  assign q_cmd.seg        = (phase_r == PH_SEGMENT);
  assign q_cmd.frame      = {fb_r[0], fb_r[1], fb_r[2], fb_r[3], fb_r[4], fb_r[5], fb_r[6], b};
  assign q_cmd.has_status = in_item.end_of_packet;
  assign q_cmd.status     = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_VERSION;
      total_r  <= '0;
      idx_r    <= '0;
      mcnt_r   <= '0;
      scnt_r   <= '0;
      left_r   <= '0;
      ver_ok_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      total_r  <= total_nxt;
      idx_r    <= idx_nxt;
      mcnt_r   <= mcnt_nxt;
      scnt_r   <= scnt_nxt;
      left_r   <= left_nxt;
      ver_ok_r <= ver_ok_nxt;
    end
  end

  // frame byte store, no reset: every entry is written before it is read
  always_ff @(posedge clk) begin
    if (fb_we) fb_r[idx_r] <= b;
  end

endmodule

// ===== src/hfp_queue.sv =====
// Short command queue between parser front and unpack back end.
// Depends on hfp_pkg.
module hfp_queue
  import hfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hfp_cmd_t wdata,
  output logic     full,
  input  logic     pop,
  output hfp_cmd_t rdata,
  output logic     empty
);

  hfp_cmd_t              mem_r [HFP_QDEPTH];
  logic [HFP_QPTR_W-1:0] wp_r, wp_nxt;
  logic [HFP_QPTR_W-1:0] rp_r, rp_nxt;
  logic [HFP_QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (cnt_r == HFP_QCNT_W'(HFP_QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == HFP_QPTR_W'(HFP_QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == HFP_QPTR_W'(HFP_QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== src/hfp_back.sv =====
// Back end: unpacks queued commands into result items, one per cycle while out_pop keeps up.
// Depends on hfp_pkg.
module hfp_back
  import hfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  hfp_cmd_t q_head,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output hfp_out_t out_item
);

  hfp_out_t out_r, out_nxt;
  logic     vld_r, vld_nxt;
  logic     fdone_r, fdone_nxt;   // frame half of head command already sent
  logic     load;
  hfp_out_t st_item;

  assign load = !vld_r || out_pop;

  always_comb begin
    st_item        = '0;
    st_item.kind   = KIND_STATUS;
    st_item.status = q_head.status;
    st_item.last   = 1'b1;

    out_nxt   = out_r;
    vld_nxt   = vld_r;
    fdone_nxt = fdone_r;
    q_pop     = 1'b0;
    if (load) begin
      if (!q_empty) begin
        vld_nxt = 1'b1;
        if (q_head.has_frame && !fdone_r) begin
          out_nxt = hfp_decode_frame(q_head.frame, q_head.seg);
          if (q_head.has_status) fdone_nxt = 1'b1;
          else                   q_pop     = 1'b1;
        end else begin
          out_nxt   = st_item;
          fdone_nxt = 1'b0;
          q_pop     = 1'b1;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      fdone_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      fdone_r <= fdone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_empty = !vld_r;
  assign out_item  = out_r;

endmodule

// ===== tb/sv/hfp_parse_mirror_pkg.sv =====
// Scoreboard class for the packet frame parser: mirrors the byte parser and checks results.
// Depends on hfp_pkg for the item structs, kind codes and status codes.
package hfp_parse_mirror_pkg;
  import hfp_pkg::*;

  typedef enum logic [2:0] {
    PP_VERSION,
    PP_MCNT_HI,
    PP_MCNT_LO,
    PP_MATRIX,
    PP_SCNT_HI,
    PP_SCNT_LO,
    PP_SEGMENT,
    PP_AFTER
  } parse_phase_t;

  class hfp_parse_mirror;
    logic [7:0]   version_reg;
    parse_phase_t phase;
    logic [19:0]  byte_total;
    logic [2:0]   frame_idx;
    logic [15:0]  matrix_count;
    logic [15:0]  segment_count;
    logic [15:0]  frames_left;
    logic [7:0]   frame_bytes [7];
    logic         version_ok;
    hfp_out_t     awaited [$];
    int           errors;

    function new();
      version_reg = '0;
      errors      = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase         = PP_VERSION;
      byte_total    = '0;
      frame_idx     = '0;
      matrix_count  = '0;
      segment_count = '0;
      frames_left   = '0;
      version_ok    = 1'b0;
      foreach (frame_bytes[k]) frame_bytes[k] = '0;
    endfunction

    function void set_version(logic [7:0] v);
      version_reg = v;
    endfunction

    // bit slicing of one 8-byte frame, byte 0 first
    function hfp_out_t unpack_frame(logic seg, logic [7:0] last_byte);
      hfp_out_t    r;
      logic [7:0]  fb [8];
      logic [5:0]  cls [3];
      logic [11:0] val [3];
      logic [7:0]  hi;
      logic [7:0]  lo;
      for (int k = 0; k < 7; k++) fb[k] = frame_bytes[k];
      fb[7] = last_byte;
      for (int i = 0; i < 3; i++) begin
        hi = fb[2 + 2*i];
        lo = fb[3 + 2*i];
        if (seg) begin
          cls[i] = lo[5:0];
          val[i] = {2'b00, hi, lo[7:6]};
        end else begin
          cls[i] = {2'b00, hi[7:4]};
          val[i] = {hi[3:0], lo};
        end
      end
      r             = '0;
      r.kind        = seg ? KIND_SEGMENT : KIND_MATRIX;
      r.msg_count   = {fb[0], fb[1][7:6]};
      r.head_bits   = fb[1][5:0];
      r.part0_class = cls[0];
      r.part0_value = val[0];
      r.part1_class = cls[1];
      r.part1_value = val[1];
      r.part2_class = cls[2];
      r.part2_value = val[2];
      return r;
    endfunction

    // first failing check wins
    function logic [2:0] packet_status();
      logic [31:0] want;
      want = 32'd5 + 32'd8 * matrix_count + 32'd8 * segment_count;
      if (!version_ok) return ST_VERSION;
      if (byte_total < 20'd4) return ST_SHORT;
      case (phase)
        PP_MCNT_HI, PP_MCNT_LO, PP_MATRIX: return ST_MATRIX_TRC;
        PP_SCNT_HI, PP_SCNT_LO:            return ST_NO_SEG_CNT;
        PP_AFTER: return ({12'd0, byte_total} == want) ? ST_VALID : ST_SIZE;
        default:  return ST_SIZE;
      endcase
    endfunction

    function void take_byte(hfp_in_t it);
      hfp_out_t   r;
      logic [7:0] b;
      b = it.data_byte;
      if (byte_total != 20'hFFFFF) byte_total++;
      case (phase)
        PP_VERSION: begin
          version_ok = (b == version_reg);
          phase      = PP_MCNT_HI;
        end
        PP_MCNT_HI: begin
          matrix_count = {8'h00, b};
          phase        = PP_MCNT_LO;
        end
        PP_MCNT_LO: begin
          matrix_count = {matrix_count[7:0], b};
          frames_left  = matrix_count;
          frame_idx    = '0;
          phase        = (frames_left != 0) ? PP_MATRIX : PP_SCNT_HI;
        end
        PP_SCNT_HI: begin
          segment_count = {8'h00, b};
          phase         = PP_SCNT_LO;
        end
        PP_SCNT_LO: begin
          segment_count = {segment_count[7:0], b};
          frames_left   = segment_count;
          frame_idx     = '0;
          phase         = (frames_left != 0) ? PP_SEGMENT : PP_AFTER;
        end
        PP_MATRIX, PP_SEGMENT: begin
          if (frame_idx < 3'd7) begin
            frame_bytes[frame_idx] = b;
            frame_idx++;
          end else begin
            awaited = {awaited, unpack_frame(phase == PP_SEGMENT, b)};
            frame_idx = '0;
            frames_left--;
            if (frames_left == 0) phase = (phase == PP_SEGMENT) ? PP_AFTER : PP_SCNT_HI;
          end
        end
        default: ;
      endcase
      if (it.end_of_packet) begin
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = packet_status();
        r.last   = 1'b1;
        awaited  = {awaited, r};
        clear_parse();
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_item(hfp_out_t got);
      hfp_out_t want;
      if (awaited.size() == 0) begin
        $error("result item with nothing outstanding: kind %0d status %0d",
               got.kind, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      check_field("kind",        want.kind,        got.kind);
      check_field("msg_count",   want.msg_count,   got.msg_count);
      check_field("head_bits",   want.head_bits,   got.head_bits);
      check_field("part0_class", want.part0_class, got.part0_class);
      check_field("part0_value", want.part0_value, got.part0_value);
      check_field("part1_class", want.part1_class, got.part1_class);
      check_field("part1_value", want.part1_value, got.part1_value);
      check_field("part2_class", want.part2_class, got.part2_class);
      check_field("part2_value", want.part2_value, got.part2_value);
      check_field("status",      want.status,      got.status);
      check_field("last",        want.last,        got.last);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// Top-level testbench for horizon_packet_frame_parser_top: drives packets, config, pops.
// Depends on hfp_pkg, hfp_parse_mirror_pkg and the parser RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hfp_pkg::*;
  import hfp_parse_mirror_pkg::*;

  // cycles with no handshake of any kind before the run is declared hung;
  // worst correct gap is one stall burst plus the trip through the pipeline
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int          PHASE_BYTES = 135;

  typedef logic [7:0] pkt_t [$];

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  hfp_in_t    in_item;
  logic       in_full;
  logic       out_empty;
  logic       out_pop;
  hfp_out_t   out_item;
  logic       cfg_valid;
  logic [7:0] cfg_data;
  logic       cfg_ready;

  hfp_parse_mirror mirror = new();

  logic [7:0]  cur_version;
  logic        bursts_on;
  int unsigned quiet_cycles = 0;

  horizon_packet_frame_parser_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready)
  );

  always #6 clk = ~clk;

  // watchdog: any accepted item or config write resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: pop with random stall bursts, check every accepted item
  initial begin
    int unsigned stall;
    stall   = 0;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall != 0) begin
        out_pop = 1'b0;
        stall--;
      end else if (bursts_on && $urandom_range(0, 11) == 0) begin
        // burst of stalled cycles, this one included
        out_pop = 1'b0;
        stall   = $urandom_range(0, 16);
      end else begin
        out_pop = 1'b1;
      end
      @(posedge clk);
      if (out_pop && !out_empty) mirror.compare_item(out_item);
    end
  end

  // one byte: optional idle burst, then hold push until the block takes it
  task automatic push_byte(input logic [7:0] b, input logic eop);
    hfp_in_t it;
    it.data_byte     = b;
    it.end_of_packet = eop;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 11) == 0) begin
      in_push = 1'b0;
      in_item = 9'($urandom);  // junk on the bus while idle
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_push = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_full);
    mirror.take_byte(it);
  endtask

  // end_of_packet rides on the final byte
  task automatic send_packet(input pkt_t q);
    foreach (q[k]) push_byte(q[k], k == q.size() - 1);
  endtask

  // stop pushing and let the block drain; bytes that make no result may
  // still be in flight, so keep waiting past the last checked result
  task automatic settle();
    @(negedge clk);
    in_push = 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    mirror.set_version(v);
    cur_version = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly well-formed packets with random frame content; the rest are
  // bad versions, truncations, trailing junk and pure noise
  task automatic rand_packet(output int n);
    pkt_t q;
    int   mode;
    int   m;
    int   s;
    int   cut;
    mode = $urandom_range(0, 19);
    m    = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
    s    = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
    if (mode == 19) begin
      repeat ($urandom_range(1, 12)) q = {q, 8'($urandom)};
      if ($urandom_range(0, 1) == 1) q[0] = cur_version;
    end else begin
      if (mode == 14 || mode == 15) begin
        q = {q, cur_version ^ 8'($urandom_range(1, 255))};
      end else begin
        q = {q, cur_version};
      end
      q = {q, 8'(m >> 8)};
      q = {q, 8'(m)};
      repeat (8 * m) q = {q, 8'($urandom)};
      q = {q, 8'(s >> 8)};
      q = {q, 8'(s)};
      repeat (8 * s) q = {q, 8'($urandom)};
      if (mode == 16 || mode == 17) begin
        cut = $urandom_range(1, q.size() - 1);
        while (q.size() > cut) void'(q.pop_back());
      end
      if (mode == 18) repeat ($urandom_range(1, 9)) q = {q, 8'($urandom)};
    end
    send_packet(q);
    n = q.size();
  endtask

  initial begin
    pkt_t pkt;
    int   sent;
    int   n;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    cur_version = '0;
    bursts_on   = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed, version register at zero ---
    write_version(8'h00);
    pkt = {8'h00};                           // one byte, version fine: too short
    send_packet(pkt);
    pkt = {8'h80};                           // version wrong beats everything
    send_packet(pkt);
    pkt = {8'h00, 8'h00, 8'h00, 8'h00};      // ends inside the segment count
    send_packet(pkt);
    pkt = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};   // smallest valid packet
    send_packet(pkt);
    pkt = {8'h00, 8'hFF, 8'hFF, 8'hAA};      // huge matrix count, truncated
    send_packet(pkt);

    // --- directed, version register at all ones ---
    write_version(8'hFF);
    // one segment frame of all ones, its last byte also ends the packet:
    // frame item must come out ahead of the status item
    pkt = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet(pkt);
    pkt = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'hC3};   // trailing bytes
    send_packet(pkt);

    // --- random phases, fresh version each; last one with no idling ---
    for (int p = 0; p < 5; p++) begin
      if (p == 4) bursts_on = 1'b0;
      write_version(8'($urandom));
      sent = 0;
      while (sent < PHASE_BYTES) begin
        rand_packet(n);
        sent += n;
      end
    end

    // drain; watchdog covers results that never show up
    @(negedge clk);
    in_push = 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
